// ===== src/lsci_pkg.sv =====
// Shared types and constants for the limited-slope centroid interpolator.
package lsci_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int OFFSET_W        = 16;
	localparam int OFFSET_FRAC     = 15;
	localparam int ACC_GUARD       = 8;
	localparam int QUEUE_DEPTH_DEF = 2;

	typedef enum logic [1:0] {
		LIM_MINMOD   = 2'd0,
		LIM_MC       = 2'd1,
		LIM_SUPERBEE = 2'd2
	} lim_mode_t;

endpackage

// ===== src/limited_slope_centroid_interp_core.sv =====
// Top level of the limited-slope centroid interpolator.
// A result passes front registers s1 and s2, the queue, then the back product, term and result registers.
// Throughput: one item per cycle while the output register does not stall, bounded by the accumulator loop.
// A full output register stalls the back end; the queue then lets the front run on.
// Reset (arst_n low, asynchronous): pipeline and queue empty, accumulator cleared,
// limiter mode back to minmod.
module limited_slope_centroid_interp_core #(
	parameter int VALUE_WIDTH = lsci_pkg::VALUE_WIDTH_DEF,
	parameter int QUEUE_DEPTH = lsci_pkg::QUEUE_DEPTH_DEF,
	localparam int IN_TDATA_W  = ((3*VALUE_WIDTH + lsci_pkg::OFFSET_W + 7) / 8) * 8,
	localparam int OUT_TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_wdata,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// center_value, left_value, right_value, centroid_offset, zero fill
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// has_left, has_right
	input  logic [1:0]             s_axis_tuser,
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// centroid_value, zero fill
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// saturated
	output logic [0:0]             m_axis_tuser
);

	localparam int ENTRY_W = 2*VALUE_WIDTH + lsci_pkg::OFFSET_W + 3;

	lsci_pkg::lim_mode_t           mode_q;
	logic                          q_push, q_pop, q_full, q_not_empty;
	logic [ENTRY_W-1:0]            q_wdata, q_rdata;
	logic signed [VALUE_WIDTH-1:0] centroid_value;
	logic                          saturated;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= lsci_pkg::LIM_MINMOD;
		end else if (cfg_we) begin
			mode_q <= lsci_pkg::lim_mode_t'(cfg_wdata);
		end
	end

	lsci_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.mode            (mode_q),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.center_value    (s_axis_tdata[VALUE_WIDTH-1:0]),
		.left_value      (s_axis_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH]),
		.right_value     (s_axis_tdata[3*VALUE_WIDTH-1:2*VALUE_WIDTH]),
		.has_left        (s_axis_tuser[0]),
		.has_right       (s_axis_tuser[1]),
		.centroid_offset (s_axis_tdata[3*VALUE_WIDTH+lsci_pkg::OFFSET_W-1:3*VALUE_WIDTH]),
		.last_direction  (s_axis_tlast),
		.q_full          (q_full),
		.q_push          (q_push),
		.q_data          (q_wdata)
	);

	lsci_fifo #(
		.DATA_W(ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (q_rdata)
	);

	lsci_back #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_not_empty    (q_not_empty),
		.q_data         (q_rdata),
		.q_pop          (q_pop),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.centroid_value (centroid_value),
		.saturated      (saturated)
	);

	always_comb begin
		m_axis_tdata                  = '0;
		m_axis_tdata[VALUE_WIDTH-1:0] = centroid_value;
		m_axis_tuser[0]               = saturated;
	end

endmodule

// ===== src/lsci_front.sv =====
// Front end: takes items, forms the one-sided differences and the limited slope.
module lsci_front #(
	parameter int VALUE_WIDTH = lsci_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  lsci_pkg::lim_mode_t                       mode,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic signed [VALUE_WIDTH-1:0]             center_value,
	input  logic signed [VALUE_WIDTH-1:0]             left_value,
	input  logic signed [VALUE_WIDTH-1:0]             right_value,
	input  logic                                      has_left,
	input  logic                                      has_right,
	input  logic signed [lsci_pkg::OFFSET_W-1:0]      centroid_offset,
	input  logic                                      last_direction,
	input  logic                                      q_full,
	output logic                                      q_push,
	output logic [2*VALUE_WIDTH+lsci_pkg::OFFSET_W+2:0] q_data
);

	localparam int D = VALUE_WIDTH + 1;
	localparam int S = VALUE_WIDTH + 2;

	logic                                 s1_v_q, s2_v_q;
	logic                                 s1_ready, s2_ready;
	logic signed [D-1:0]                  dwl_s1, dwr_s1;
	logic signed [VALUE_WIDTH-1:0]        center_s1, center_s2;
	logic signed [lsci_pkg::OFFSET_W-1:0] offset_s1, offset_s2;
	logic                                 last_s1, last_s2;
	logic signed [S-1:0]                  slope_s2;

	logic signed [D-1:0] dl_raw, dr_raw, dwl, dwr;
	logic                l_neg, l_pos, r_neg, r_pos, same;
	logic [D-1:0]        ml, mr, min_m;
	logic signed [S-1:0] c_sum;
	logic [S-1:0]        mag_c, mc_a, mc_b, mc_m, two_ml, two_mr, sb1, sb2, sb_m, mag;
	logic signed [S-1:0] slope;

	assign s2_ready = !s2_v_q || !q_full;
	assign s1_ready = !s1_v_q || s2_ready;
	assign in_ready = s1_ready;
	assign q_push   = s2_v_q && !q_full;
	assign q_data   = {last_s2, offset_s2, center_s2, slope_s2};

	always_comb begin
		dl_raw = {center_value[VALUE_WIDTH-1], center_value}
			- {left_value[VALUE_WIDTH-1], left_value};
		dr_raw = {right_value[VALUE_WIDTH-1], right_value}
			- {center_value[VALUE_WIDTH-1], center_value};
		dwl = has_left ? dl_raw : (has_right ? dr_raw : '0);
		dwr = has_right ? dr_raw : (has_left ? dl_raw : '0);
	end

	always_comb begin
		l_neg = dwl_s1[D-1];
		r_neg = dwr_s1[D-1];
		l_pos = !l_neg && (dwl_s1 != '0);
		r_pos = !r_neg && (dwr_s1 != '0);
		same  = (l_pos && r_pos) || (l_neg && r_neg);
		ml    = l_neg ? -dwl_s1 : dwl_s1;
		mr    = r_neg ? -dwr_s1 : dwr_s1;
		min_m = (ml < mr) ? ml : mr;
		// monotonized central
		c_sum = {dwl_s1[D-1], dwl_s1} + {dwr_s1[D-1], dwr_s1};
		mag_c = c_sum[S-1] ? -c_sum : c_sum;
		mc_a  = {1'b0, mag_c[S-1:1]};
		mc_b  = {min_m, 1'b0};
		mc_m  = (mc_a < mc_b) ? mc_a : mc_b;
		// superbee, signs already known equal
		two_ml = {ml, 1'b0};
		two_mr = {mr, 1'b0};
		sb1    = ({1'b0, ml} < two_mr) ? {1'b0, ml} : two_mr;
		sb2    = ({1'b0, mr} < two_ml) ? {1'b0, mr} : two_ml;
		sb_m   = (sb1 > sb2) ? sb1 : sb2;
		case (mode)
			lsci_pkg::LIM_MINMOD:   mag = {1'b0, min_m};
			lsci_pkg::LIM_MC:       mag = mc_m;
			lsci_pkg::LIM_SUPERBEE: mag = sb_m;
			default:                mag = '0;
		endcase
		if (!same) begin
			slope = '0;
		end else if (l_neg) begin
			slope = -$signed(mag);
		end else begin
			slope = $signed(mag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
		end else begin
			if (s1_ready) s1_v_q <= in_valid;
			if (s2_ready) s2_v_q <= s1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && in_valid) begin
			dwl_s1    <= dwl;
			dwr_s1    <= dwr;
			center_s1 <= center_value;
			offset_s1 <= centroid_offset;
			last_s1   <= last_direction;
		end
		if (s2_ready && s1_v_q) begin
			slope_s2  <= slope;
			center_s2 <= center_s1;
			offset_s2 <= offset_s1;
			last_s2   <= last_s1;
		end
	end

endmodule

// ===== src/lsci_fifo.sv =====
// Short register queue between the front and back ends.
module lsci_fifo #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = lsci_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output logic [DATA_W-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== src/lsci_back.sv =====
// Back end: slope times offset, rounding, saturating accumulation and result register.
module lsci_back #(
	parameter int VALUE_WIDTH = lsci_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        q_not_empty,
	input  logic [2*VALUE_WIDTH+lsci_pkg::OFFSET_W+2:0] q_data,
	output logic                                        q_pop,
	output logic                                        out_valid,
	input  logic                                        out_ready,
	output logic signed [VALUE_WIDTH-1:0]               centroid_value,
	output logic                                        saturated
);

	localparam int S     = VALUE_WIDTH + 2;
	localparam int OW    = lsci_pkg::OFFSET_W;
	localparam int P_W   = S + OW;
	localparam int T_W   = P_W - lsci_pkg::OFFSET_FRAC;
	localparam int ACC_W = VALUE_WIDTH + lsci_pkg::ACC_GUARD;
	localparam int EXT_T = ACC_W + 1 - T_W;
	localparam int EXT_A = ACC_W - VALUE_WIDTH;
	localparam int HI_W  = ACC_W - VALUE_WIDTH + 1;

	logic signed [S-1:0]           q_slope;
	logic signed [VALUE_WIDTH-1:0] q_center;
	logic signed [OW-1:0]          q_offset;
	logic                          q_last;

	logic                          advance;
	logic                          b1_v_q, b2_v_q, out_v_q;
	logic signed [P_W-1:0]         prod_s1;
	logic signed [VALUE_WIDTH-1:0] center_s1, center_s2;
	logic                          last_s1, last_s2;
	logic signed [T_W-1:0]         term_s2;
	logic signed [ACC_W-1:0]       acc_q;
	logic                          in_cell_q;

	logic signed [P_W-1:0]         rounded;
	logic signed [ACC_W-1:0]       base, acc_sat;
	logic signed [ACC_W:0]         sum;
	logic signed [VALUE_WIDTH-1:0] out_clip;
	logic                          clip_hit;
	logic [HI_W-1:0]               hi_bits;

	assign {q_last, q_offset, q_center, q_slope} = q_data;
	assign advance   = !out_v_q || out_ready;
	assign q_pop     = advance && q_not_empty;
	assign out_valid = out_v_q;

	always_comb begin
		rounded = prod_s1 + (P_W'(1) <<< (lsci_pkg::OFFSET_FRAC - 1));
		base = in_cell_q ? acc_q : {{EXT_A{center_s2[VALUE_WIDTH-1]}}, center_s2};
		sum  = {base[ACC_W-1], base} + {{EXT_T{term_s2[T_W-1]}}, term_s2};
		if (sum[ACC_W] != sum[ACC_W-1]) begin
			acc_sat = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			acc_sat = sum[ACC_W-1:0];
		end
		hi_bits  = acc_sat[ACC_W-1:VALUE_WIDTH-1];
		clip_hit = (hi_bits != '0) && (hi_bits != '1);
		if (clip_hit) begin
			out_clip = acc_sat[ACC_W-1] ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
				: {1'b0, {(VALUE_WIDTH-1){1'b1}}};
		end else begin
			out_clip = acc_sat[VALUE_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_v_q    <= 1'b0;
			b2_v_q    <= 1'b0;
			out_v_q   <= 1'b0;
			acc_q     <= '0;
			in_cell_q <= 1'b0;
		end else if (advance) begin
			b1_v_q  <= q_not_empty;
			b2_v_q  <= b1_v_q;
			out_v_q <= b2_v_q && last_s2;
			if (b2_v_q) begin
				if (last_s2) begin
					acc_q     <= '0;
					in_cell_q <= 1'b0;
				end else begin
					acc_q     <= acc_sat;
					in_cell_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (q_not_empty) begin
				prod_s1   <= q_slope * q_offset;
				center_s1 <= q_center;
				last_s1   <= q_last;
			end
			if (b1_v_q) begin
				term_s2   <= rounded[P_W-1:lsci_pkg::OFFSET_FRAC];
				center_s2 <= center_s1;
				last_s2   <= last_s1;
			end
			if (b2_v_q && last_s2) begin
				centroid_value <= out_clip;
				saturated      <= clip_hit;
			end
		end
	end

endmodule
